### sv/vsf_pkg.sv
package vsf_pkg;

  // Width of every field on the streaming ports.
  localparam int FIELD_W = 32;

  // Defaults for the arithmetic width and the number of fraction bits.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int NUM_ROWS   = 9;
  localparam int NUM_VEL    = 3;
  localparam int NUM_OUT    = 12;
  localparam int IN_DATA_W  = 5 * FIELD_W;
  localparam int OUT_DATA_W = NUM_OUT * FIELD_W;
  localparam int KIND_W     = 2;

  // Depth of the queue between the front end and the arithmetic back end.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [KIND_W-1:0] {
    FUNC_ROW_U = 2'd0,
    FUNC_ROW_V = 2'd1,
    FUNC_ROW_W = 2'd2,
    FUNC_TEMP  = 2'd3
  } func_t;

  typedef logic [FIELD_W-1:0] field_t;

  // One queued point: a snapshot of the stored rows plus the temperature beat.
  typedef struct packed {
    field_t [NUM_ROWS-1:0] rows;
    field_t [NUM_VEL-1:0]  vel;
    field_t                grad_x;
    field_t                grad_y;
    field_t                grad_z;
    field_t                scalar_a;
    field_t                scalar_b;
  } point_t;

endpackage

### sv/vsf_front.sv
module vsf_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [vsf_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [vsf_pkg::KIND_W-1:0]  in_tuser,
  input  logic                        q_full,
  output logic                        q_push,
  output vsf_pkg::point_t             q_data
);

  import vsf_pkg::*;

  field_t [NUM_ROWS-1:0] rows_r;
  field_t [NUM_VEL-1:0]  vel_r;
  logic                  accept;
  logic                  is_temp;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign is_temp   = (func_t'(in_tuser) == FUNC_TEMP);
  assign q_push    = accept && is_temp;

  // A temperature beat takes a snapshot of the rows as they stand before it.
  always_comb begin
    q_data.rows     = rows_r;
    q_data.vel      = vel_r;
    q_data.grad_x   = in_tdata[0*FIELD_W +: FIELD_W];
    q_data.grad_y   = in_tdata[1*FIELD_W +: FIELD_W];
    q_data.grad_z   = in_tdata[2*FIELD_W +: FIELD_W];
    q_data.scalar_a = in_tdata[3*FIELD_W +: FIELD_W];
    q_data.scalar_b = in_tdata[4*FIELD_W +: FIELD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0;
      vel_r  <= '0;
    end else if (accept && !is_temp) begin
      for (int i = 0; i < NUM_VEL; i++) begin
        if (in_tuser == KIND_W'(i)) begin
          rows_r[3*i+0] <= in_tdata[0*FIELD_W +: FIELD_W];
          rows_r[3*i+1] <= in_tdata[1*FIELD_W +: FIELD_W];
          rows_r[3*i+2] <= in_tdata[2*FIELD_W +: FIELD_W];
          vel_r[i]      <= in_tdata[3*FIELD_W +: FIELD_W];
        end
      end
    end
  end

endmodule

### sv/vsf_queue.sv
module vsf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vsf_pkg::point_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output vsf_pkg::point_t pop_data
);

  import vsf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  point_t [QUEUE_DEPTH-1:0] entry_r;
  logic [PTR_W-1:0]         wr_ptr_r;
  logic [PTR_W-1:0]         rd_ptr_r;
  logic [CNT_W-1:0]         count_r;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = entry_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("queue count lost a write");
`endif

endmodule

### sv/vsf_back.sv
module vsf_back #(
  parameter int DATA_WIDTH = vsf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = vsf_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  vsf_pkg::point_t                q_data,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [vsf_pkg::OUT_DATA_W-1:0] out_tdata
);

  import vsf_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int EXT_W = (DW > FIELD_W) ? DW : FIELD_W;
  localparam int AW    = (DW > FRAC_BITS + 2) ? DW : FRAC_BITS + 2;
  localparam int PW    = AW + DW;
  localparam int RES_W = $clog2(NUM_OUT);

  typedef logic signed [DW-1:0] word_t;

  localparam word_t                    WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam word_t                    WMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW:0]       SMAX = (DW+1)'(WMAX);
  localparam logic signed [DW:0]       SMIN = (DW+1)'(WMIN);
  localparam logic signed [EXT_W-1:0]  EMAX = EXT_W'(WMAX);
  localparam logic signed [EXT_W-1:0]  EMIN = EXT_W'(WMIN);
  localparam logic signed [EXT_W-1:0]  FMAX = EXT_W'(signed'({1'b0, {(FIELD_W-1){1'b1}}}));
  localparam logic signed [EXT_W-1:0]  FMIN = EXT_W'(signed'({1'b1, {(FIELD_W-1){1'b0}}}));
  localparam logic signed [PW-1:0]     PMAX = PW'(WMAX);
  localparam logic signed [PW-1:0]     PMIN = PW'(WMIN);
  localparam logic signed [AW-1:0]     TWO_THIRDS =
    AW'(((64'd2 << FRAC_BITS) + 64'd1) / 64'd3);

  localparam logic [RES_W-1:0] RES_SXX = RES_W'(0);
  localparam logic [RES_W-1:0] RES_SXY = RES_W'(1);
  localparam logic [RES_W-1:0] RES_SXZ = RES_W'(2);
  localparam logic [RES_W-1:0] RES_SYY = RES_W'(3);
  localparam logic [RES_W-1:0] RES_SYZ = RES_W'(4);
  localparam logic [RES_W-1:0] RES_SZZ = RES_W'(5);
  localparam logic [RES_W-1:0] RES_CX  = RES_W'(6);
  localparam logic [RES_W-1:0] RES_CY  = RES_W'(7);
  localparam logic [RES_W-1:0] RES_CZ  = RES_W'(8);
  localparam logic [RES_W-1:0] RES_EX  = RES_W'(9);
  localparam logic [RES_W-1:0] RES_EY  = RES_W'(10);
  localparam logic [RES_W-1:0] RES_EZ  = RES_W'(11);

  // One step per product, in the order that the saturating sums need.
  typedef enum logic [4:0] {
    OP_TD, OP_SXX, OP_SXY, OP_SXZ, OP_SYY, OP_SYZ, OP_SZZ,
    OP_CX, OP_CY, OP_CZ,
    OP_EX_U, OP_EX_V, OP_EX_W,
    OP_EY_U, OP_EY_V, OP_EY_W,
    OP_EZ_U, OP_EZ_V, OP_EZ_W
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_OPB, S_MUL, S_WB, S_FIN, S_EMIT
  } state_t;

  state_t                      state_r;
  op_t                         op_r;
  word_t [NUM_ROWS-1:0]        row_r;
  word_t [NUM_VEL-1:0]         vel_r;
  word_t [2:0]                 grad_r;
  word_t                       sa_r;
  word_t                       sb_r;
  word_t                       td_r;
  word_t [NUM_OUT-1:0]         res_r;
  word_t                       pre_r;
  word_t                       opb_r;
  logic signed [PW-1:0]        prod_r;
  logic                        out_valid_r;
  logic [OUT_DATA_W-1:0]       out_data_r;

  word_t                       pre_p;
  word_t                       pre_q;
  word_t                       opr;
  logic                        opr_sub;
  logic signed [AW-1:0]        opa;
  logic [RES_W-1:0]            dest;
  logic                        to_td;
  logic                        acc;

  word_t                       pre_nxt;
  word_t                       opb_nxt;
  logic signed [PW-1:0]        prod_nxt;
  word_t                       wb_val;
  word_t                       acc_nxt;
  logic                        out_free;

  function automatic word_t from_field(input field_t x);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(signed'(x));
    if (e > EMAX) begin
      return WMAX;
    end
    if (e < EMIN) begin
      return WMIN;
    end
    return DW'(e);
  endfunction

  function automatic field_t to_field(input word_t v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(v);
    if (e > FMAX) begin
      return FMAX[FIELD_W-1:0];
    end
    if (e < FMIN) begin
      return FMIN[FIELD_W-1:0];
    end
    return e[FIELD_W-1:0];
  endfunction

  function automatic word_t addsub_sat(input word_t a, input word_t b, input logic sub);
    logic signed [DW:0] s;
    s = sub ? ((DW+1)'(a) - (DW+1)'(b)) : ((DW+1)'(a) + (DW+1)'(b));
    if (s > SMAX) begin
      return WMAX;
    end
    if (s < SMIN) begin
      return WMIN;
    end
    return DW'(s);
  endfunction

  // Operand selection for the current step.
  always_comb begin
    pre_p   = '0;
    pre_q   = '0;
    opr     = '0;
    opr_sub = 1'b0;
    opa     = AW'(sa_r);
    dest    = RES_SXX;
    to_td   = 1'b0;
    acc     = 1'b0;
    case (op_r)
      OP_TD: begin
        pre_p = row_r[0];
        pre_q = row_r[4];
        opr   = row_r[8];
        opa   = TWO_THIRDS;
        to_td = 1'b1;
      end
      OP_SXX: begin
        pre_p   = row_r[0];
        pre_q   = row_r[0];
        opr     = td_r;
        opr_sub = 1'b1;
        dest    = RES_SXX;
      end
      OP_SXY: begin
        pre_p = row_r[1];
        pre_q = row_r[3];
        dest  = RES_SXY;
      end
      OP_SXZ: begin
        pre_p = row_r[2];
        pre_q = row_r[6];
        dest  = RES_SXZ;
      end
      OP_SYY: begin
        pre_p   = row_r[4];
        pre_q   = row_r[4];
        opr     = td_r;
        opr_sub = 1'b1;
        dest    = RES_SYY;
      end
      OP_SYZ: begin
        pre_p = row_r[5];
        pre_q = row_r[7];
        dest  = RES_SYZ;
      end
      OP_SZZ: begin
        pre_p   = row_r[8];
        pre_q   = row_r[8];
        opr     = td_r;
        opr_sub = 1'b1;
        dest    = RES_SZZ;
      end
      OP_CX: begin
        pre_p = grad_r[0];
        opa   = AW'(sb_r);
        dest  = RES_CX;
      end
      OP_CY: begin
        pre_p = grad_r[1];
        opa   = AW'(sb_r);
        dest  = RES_CY;
      end
      OP_CZ: begin
        pre_p = grad_r[2];
        opa   = AW'(sb_r);
        dest  = RES_CZ;
      end
      OP_EX_U: begin
        pre_p = res_r[RES_SXX];
        opa   = AW'(vel_r[0]);
        dest  = RES_EX;
      end
      OP_EX_V: begin
        pre_p = res_r[RES_SXY];
        opa   = AW'(vel_r[1]);
        dest  = RES_EX;
        acc   = 1'b1;
      end
      OP_EX_W: begin
        pre_p = res_r[RES_SXZ];
        opa   = AW'(vel_r[2]);
        dest  = RES_EX;
        acc   = 1'b1;
      end
      OP_EY_U: begin
        pre_p = res_r[RES_SXY];
        opa   = AW'(vel_r[0]);
        dest  = RES_EY;
      end
      OP_EY_V: begin
        pre_p = res_r[RES_SYY];
        opa   = AW'(vel_r[1]);
        dest  = RES_EY;
        acc   = 1'b1;
      end
      OP_EY_W: begin
        pre_p = res_r[RES_SYZ];
        opa   = AW'(vel_r[2]);
        dest  = RES_EY;
        acc   = 1'b1;
      end
      OP_EZ_U: begin
        pre_p = res_r[RES_SXZ];
        opa   = AW'(vel_r[0]);
        dest  = RES_EZ;
      end
      OP_EZ_V: begin
        pre_p = res_r[RES_SYZ];
        opa   = AW'(vel_r[1]);
        dest  = RES_EZ;
        acc   = 1'b1;
      end
      OP_EZ_W: begin
        pre_p = res_r[RES_SZZ];
        opa   = AW'(vel_r[2]);
        dest  = RES_EZ;
        acc   = 1'b1;
      end
      default: begin
        pre_p = '0;
      end
    endcase
  end

  // Adding zero leaves an in-range value untouched, so every step can share
  // the same add, add-or-subtract, multiply, write-back sequence.
  always_comb begin
    logic signed [PW-1:0] sh;
    pre_nxt  = addsub_sat(pre_p, pre_q, 1'b0);
    opb_nxt  = addsub_sat(pre_r, opr, opr_sub);
    prod_nxt = PW'(opa) * PW'(opb_r);
    sh       = prod_r >>> FRAC_BITS;
    if (sh > PMAX) begin
      wb_val = WMAX;
    end else if (sh < PMIN) begin
      wb_val = WMIN;
    end else begin
      wb_val = DW'(sh);
    end
    acc_nxt = acc ? addsub_sat(res_r[dest], wb_val, 1'b0) : wb_val;
  end

  assign out_free   = !out_valid_r || out_tready;
  assign q_pop      = (state_r == S_IDLE) && q_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_TD;
      out_valid_r <= 1'b0;
    end else begin
      // The emit step drives the valid itself when it hands over a new beat.
      if (out_valid_r && out_tready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            for (int i = 0; i < NUM_ROWS; i++) begin
              row_r[i] <= from_field(q_data.rows[i]);
            end
            for (int i = 0; i < NUM_VEL; i++) begin
              vel_r[i] <= from_field(q_data.vel[i]);
            end
            grad_r[0] <= from_field(q_data.grad_x);
            grad_r[1] <= from_field(q_data.grad_y);
            grad_r[2] <= from_field(q_data.grad_z);
            sa_r      <= from_field(q_data.scalar_a);
            sb_r      <= from_field(q_data.scalar_b);
            op_r      <= OP_TD;
            state_r   <= S_PRE;
          end
        end
        S_PRE: begin
          pre_r   <= pre_nxt;
          state_r <= S_OPB;
        end
        S_OPB: begin
          opb_r   <= opb_nxt;
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= S_WB;
        end
        S_WB: begin
          if (to_td) begin
            td_r <= wb_val;
          end else begin
            res_r[dest] <= acc_nxt;
          end
          if (op_r == OP_EZ_W) begin
            state_r <= S_FIN;
          end else begin
            op_r    <= op_t'(op_r + 1'b1);
            state_r <= S_PRE;
          end
        end
        S_FIN: begin
          res_r[RES_EX] <= addsub_sat(res_r[RES_EX], res_r[RES_CX], 1'b0);
          res_r[RES_EY] <= addsub_sat(res_r[RES_EY], res_r[RES_CY], 1'b0);
          res_r[RES_EZ] <= addsub_sat(res_r[RES_EZ], res_r[RES_CZ], 1'b0);
          state_r       <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            for (int i = 0; i < NUM_OUT; i++) begin
              out_data_r[i*FIELD_W +: FIELD_W] <= to_field(res_r[i]);
            end
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_start_at_td: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_PRE) && (op_r == OP_TD))
    else $error("point did not start at the divergence step");
  a_last_step_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) && (op_r == OP_EZ_W) |=> (state_r == S_FIN))
    else $error("conduction terms not added after the last product");
  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EMIT))
    else $error("result beat raised outside the emit step");
`endif

endmodule

### sv/viscous_stress_flux_point_top.sv
// Flow: a temperature beat passes the queue; the back end then runs 19 products on the single
// shared multiplier in four steps each (S_PRE, S_OPB, S_MUL, S_WB), then S_FIN and S_EMIT, and
// pops no new point till S_EMIT ends; row beats are taken one per cycle while the queue has room.
// The two-entry point queue lets the front end keep taking beats while a result waits.
// Reset: synchronous, active low; the stored rows and velocities clear to zero and
// the queue, sequencer and output beat are emptied.
module viscous_stress_flux_point_top #(
  parameter int DATA_WIDTH = vsf_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = vsf_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata from bit 0 up: grad_x, grad_y, grad_z, scalar_a, scalar_b (32 bits each).
  input  logic [vsf_pkg::IN_DATA_W-1:0]   in_tdata,
  // in_tuser: func, the item kind (u row, v row, w row, temperature and compute).
  input  logic [vsf_pkg::KIND_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata from bit 0 up: stress_xx, stress_xy, stress_xz, stress_yy, stress_yz,
  // stress_zz, conduction_x, conduction_y, conduction_z, energy_flux_x,
  // energy_flux_y, energy_flux_z (32 bits each).
  output logic [vsf_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import vsf_pkg::*;

  // The front end holds the velocity rows and snapshots them into a queue
  // entry when the temperature beat arrives; the back end works through the
  // stress, conduction and energy terms with one multiplier.
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  point_t q_in;
  point_t q_out;

  vsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  vsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  vsf_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### bench/vsf_flux_tb_pkg.sv
package vsf_flux_tb_pkg;
  import vsf_pkg::*;

  localparam int     FRAC_Q   = FRAC_BITS_DEF;
  localparam longint WORD_MAX = (longint'(1) << (DATA_WIDTH_DEF - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;
  // Nearest fixed-point value of two thirds.
  localparam longint TWO_THIRDS_FX = ((longint'(2) << FRAC_Q) + 1) / 3;

  function automatic longint clip_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint sum_sat(longint a, longint b);
    return clip_word(a + b);
  endfunction

  function automatic longint diff_sat(longint a, longint b);
    return clip_word(a - b);
  endfunction

  // Operands never exceed the word range, so the product fits in 64 bits.
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clip_word(p >>> FRAC_Q);
  endfunction

  function automatic longint field_value(logic [IN_DATA_W-1:0] data, int idx);
    field_t raw;
    raw = data[idx*FIELD_W +: FIELD_W];
    return clip_word(longint'($signed(raw)));
  endfunction

  class flux_tracker;
    longint grad_row[NUM_ROWS];
    longint vel[NUM_VEL];
    logic [OUT_DATA_W-1:0] pending_flux[$];
    string field_tag[NUM_OUT];
    int mismatch_count;
    int result_index;

    function new();
      foreach (grad_row[i]) grad_row[i] = 0;
      foreach (vel[i]) vel[i] = 0;
      field_tag = '{"stress_xx", "stress_xy", "stress_xz", "stress_yy", "stress_yz",
                    "stress_zz", "conduction_x", "conduction_y", "conduction_z",
                    "energy_flux_x", "energy_flux_y", "energy_flux_z"};
      mismatch_count = 0;
      result_index = 0;
    endfunction

    function void take_beat(func_t kind, logic [IN_DATA_W-1:0] data);
      longint gx, gy, gz, sa, sb, dv, td;
      longint s[6];
      longint c[3];
      longint e[3];
      logic [OUT_DATA_W-1:0] want;
      int base;
      gx = field_value(data, 0);
      gy = field_value(data, 1);
      gz = field_value(data, 2);
      sa = field_value(data, 3);
      sb = field_value(data, 4);
      if (kind != FUNC_TEMP) begin
        base = 3 * int'(kind);
        grad_row[base]     = gx;
        grad_row[base + 1] = gy;
        grad_row[base + 2] = gz;
        vel[int'(kind)]    = sa;
        return;
      end
      dv = sum_sat(sum_sat(grad_row[0], grad_row[4]), grad_row[8]);
      td = fx_mul(dv, TWO_THIRDS_FX);
      s[0] = fx_mul(sa, diff_sat(sum_sat(grad_row[0], grad_row[0]), td));
      s[1] = fx_mul(sa, sum_sat(grad_row[1], grad_row[3]));
      s[2] = fx_mul(sa, sum_sat(grad_row[2], grad_row[6]));
      s[3] = fx_mul(sa, diff_sat(sum_sat(grad_row[4], grad_row[4]), td));
      s[4] = fx_mul(sa, sum_sat(grad_row[5], grad_row[7]));
      s[5] = fx_mul(sa, diff_sat(sum_sat(grad_row[8], grad_row[8]), td));
      c[0] = fx_mul(sb, gx);
      c[1] = fx_mul(sb, gy);
      c[2] = fx_mul(sb, gz);
      e[0] = sum_sat(sum_sat(sum_sat(fx_mul(vel[0], s[0]), fx_mul(vel[1], s[1])),
                             fx_mul(vel[2], s[2])), c[0]);
      e[1] = sum_sat(sum_sat(sum_sat(fx_mul(vel[0], s[1]), fx_mul(vel[1], s[3])),
                             fx_mul(vel[2], s[4])), c[1]);
      e[2] = sum_sat(sum_sat(sum_sat(fx_mul(vel[0], s[2]), fx_mul(vel[1], s[4])),
                             fx_mul(vel[2], s[5])), c[2]);
      for (int i = 0; i < 6; i++) want[i*FIELD_W +: FIELD_W] = field_t'(s[i]);
      for (int i = 0; i < 3; i++) begin
        want[(6 + i)*FIELD_W +: FIELD_W] = field_t'(c[i]);
        want[(9 + i)*FIELD_W +: FIELD_W] = field_t'(e[i]);
      end
      pending_flux.push_back(want);
    endfunction

    function void check_flux_beat(logic [OUT_DATA_W-1:0] got);
      logic [OUT_DATA_W-1:0] want;
      if (pending_flux.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with none expected: %h", result_index, got);
        result_index++;
        return;
      end
      want = pending_flux.pop_front();
      for (int i = 0; i < NUM_OUT; i++) begin
        if (got[i*FIELD_W +: FIELD_W] !== want[i*FIELD_W +: FIELD_W]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d %s: expected %h, got %h", result_index, field_tag[i],
                     want[i*FIELD_W +: FIELD_W], got[i*FIELD_W +: FIELD_W]);
        end
      end
      result_index++;
    endfunction

    function int pending();
      return pending_flux.size();
    endfunction
  endclass

endpackage

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vsf_pkg::*;
  import vsf_flux_tb_pkg::*;

  // The receiver holds off once for this many cycles so that the point queue
  // fills and the block has to stall its input.
  localparam int HOLD_CYCLES   = 1500;
  // Cycles without any accepted beat on either side before the run is abandoned.
  // The worst legal stretch is the hold-off plus a long gap plus one result latency.
  localparam int WATCHDOG_LIM  = 10000;
  localparam int RANDOM_BEATS  = 900;
  localparam int DRAIN_CYCLES  = 120;

  localparam field_t MAXV = 32'h7fff_ffff;
  localparam field_t MINV = 32'h8000_0000;
  localparam field_t ONE  = 32'h0001_0000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [KIND_W-1:0]     in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  flux_tracker tracker = new();

  // Sender and receiver idle settings; hold_req starts the one long hold-off.
  bit in_idle_on = 1'b1;
  bit hold_req   = 1'b0;
  bit hold_done  = 1'b0;
  int beats_sent = 0;

  viscous_stress_flux_point_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Value classes: 0 is within about two units, 1 within a few hundred, 2 is any
  // word, and 3 mixes the corner values so that saturation shows up often.
  function automatic int pick_mode();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 15) return 1;
    if (r < 18) return 2;
    return 3;
  endfunction

  function automatic field_t rand_val(int mode);
    case (mode)
      0: return field_t'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      1: return field_t'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      2: return field_t'($urandom);
      default: begin
        case ($urandom_range(0, 5))
          0: return MAXV;
          1: return MINV;
          2: return '0;
          3: return 32'h0000_0001;
          4: return 32'hffff_ffff;
          default: return field_t'($urandom);
        endcase
      end
    endcase
  endfunction

  // Offers one beat and returns at the edge where it is accepted. The valid is
  // only lowered when a gap follows, so it never falls and rises in one step.
  task automatic send_row(input func_t kind, input field_t gx, input field_t gy,
                          input field_t gz, input field_t sa, input field_t sb);
    int gap;
    gap = in_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {sb, sa, gz, gy, gx};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic send_rand_row(input func_t kind, input int mode);
    send_row(kind, rand_val(mode), rand_val(mode), rand_val(mode), rand_val(mode),
             rand_val(mode));
  endtask

  task automatic run_directed();
    // A temperature beat straight after reset works on the all-zero rows.
    send_row(FUNC_TEMP, MAXV, MINV, ONE, ONE, MAXV);
    // An ordinary point in natural order.
    send_row(FUNC_ROW_U, ONE, 32'h0000_8000, 32'hffff_c000, 32'h0002_0000, MAXV);
    send_row(FUNC_ROW_V, 32'hffff_0000, 32'h0003_0000, 32'h0000_8000, 32'hfffe_8000, MINV);
    send_row(FUNC_ROW_W, 32'h0000_4000, 32'hffff_4000, 32'h0002_0000, 32'h0000_8000, '0);
    send_row(FUNC_TEMP, ONE, 32'hfffe_0000, 32'h0000_2000, 32'h0000_8000, 32'h0004_0000);
    // A repeated u row replaces the first one.
    send_row(FUNC_ROW_U, 32'h0003_0000, 32'h0001_8000, ONE, 32'h0001_0000, '0);
    send_row(FUNC_ROW_U, 32'hffff_0000, 32'h0000_0001, 32'hffff_ffff, 32'hffff_0000, '0);
    send_row(FUNC_TEMP, 32'h0000_0001, 32'hffff_ffff, '0, ONE, ONE);
    // Rows at the top value, then at the bottom; temperature beats mix both.
    send_row(FUNC_ROW_U, MAXV, MAXV, MAXV, MAXV, MAXV);
    send_row(FUNC_ROW_V, MAXV, MAXV, MAXV, MAXV, MAXV);
    send_row(FUNC_ROW_W, MAXV, MAXV, MAXV, MAXV, MAXV);
    send_row(FUNC_TEMP, MINV, MINV, MINV, MAXV, MINV);
    send_row(FUNC_ROW_U, MINV, MINV, MINV, MINV, MINV);
    send_row(FUNC_ROW_V, MINV, MINV, MINV, MINV, MINV);
    send_row(FUNC_ROW_W, MINV, MINV, MINV, MINV, MINV);
    send_row(FUNC_TEMP, MAXV, MAXV, MAXV, MINV, MAXV);
    // Only off-diagonal gradients: the shear terms carry no divergence part.
    send_row(FUNC_ROW_U, '0, ONE, 32'h0002_0000, ONE, '0);
    send_row(FUNC_ROW_V, 32'hffff_0000, '0, 32'h0000_8000, ONE, '0);
    send_row(FUNC_ROW_W, 32'h0003_0000, 32'hffff_8000, '0, ONE, '0);
    send_row(FUNC_TEMP, '0, '0, '0, ONE, '0);
    // Rows in reverse order, then a second temperature beat on the same rows,
    // which shows that a temperature beat leaves the stored rows alone.
    send_row(FUNC_ROW_W, 32'h0000_0001, 32'h0001_0000, 32'hffff_ffff, 32'h0000_c000, MAXV);
    send_row(FUNC_ROW_V, 32'h0000_8000, 32'hffff_ffff, 32'h0001_0000, 32'hffff_4000, MINV);
    send_row(FUNC_ROW_U, 32'hfffe_0000, 32'h0000_0001, 32'h0000_4000, 32'h0001_8000, ONE);
    send_row(FUNC_TEMP, 32'h0000_8000, 32'h0001_0000, 32'hffff_0000, 32'h0002_0000, ONE);
    send_row(FUNC_TEMP, 32'hffff_ffff, 32'h7fff_0000, 32'h8000_ffff, 32'hffff_8000, MINV);
  endtask

  // Mostly complete points with random content, sometimes in shuffled order;
  // the rest are points with missing or repeated rows and lone beats of any kind.
  task automatic run_random();
    int stop_at, r, mode, n, tmp, j;
    int order[3];
    stop_at = beats_sent + RANDOM_BEATS;
    while (beats_sent < stop_at) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      mode = pick_mode();
      r = $urandom_range(0, 99);
      if (r < 80) begin
        order = '{0, 1, 2};
        if ($urandom_range(0, 9) < 3) begin
          for (int i = 0; i < 3; i++) begin
            j = $urandom_range(0, 2);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
          end
        end
        for (int i = 0; i < 3; i++) send_rand_row(func_t'(order[i]), mode);
        send_rand_row(FUNC_TEMP, mode);
      end else if (r < 90) begin
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) send_rand_row(func_t'($urandom_range(0, 2)), mode);
        send_rand_row(FUNC_TEMP, mode);
      end else begin
        send_rand_row(func_t'($urandom_range(0, 3)), 2);
      end
    end
  endtask

  // Monitor: every accepted input beat feeds the predictor, every accepted
  // result beat is checked against the oldest predicted flux. Signals are read
  // at the edge before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) tracker.take_beat(func_t'(in_tuser), in_tdata);
    if (rst_n && out_tvalid && out_tready) tracker.check_flux_beat(out_tdata);
  end

  // Receiver: random back-pressure in stretches, some of them with none at all,
  // plus the single long hold-off once the random part has begun.
  initial begin
    int gap, burst_left;
    bit idle_on;
    burst_left = 0;
    idle_on = 1'b1;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (burst_left == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
        burst_left = $urandom_range(20, 200);
      end
      burst_left--;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: any cycle that moves a beat on either side restarts the count.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIM) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Main sequence: reset, directed points, random points, then drain.
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    hold_req = 1'b1;
    run_random();
    in_tvalid <= 1'b0;
    // One more edge makes sure the monitor has noted the last accepted beat.
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    // Let any stray result beat show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/vsf_pkg.sv
sv/vsf_front.sv
sv/vsf_queue.sv
sv/vsf_back.sv
sv/viscous_stress_flux_point_top.sv
bench/vsf_flux_tb_pkg.sv
bench/tb_top.sv
